// ===== hw/rtl/rtt_estimator_rto_assert.svh =====
// Assertion macros shared by the RTT estimator RTL.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef RTT_ESTIMATOR_RTO_ASSERT_SVH
`define RTT_ESTIMATOR_RTO_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RTO_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rtt estimator: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RTO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rtt estimator: next-cycle check failed");

`endif

// ===== hw/rtl/rtt_rto_pkg.sv =====
// Package for the RTT estimator: widths, register indexes and word types.
// Depends on nothing; used by rtt_estimator_rto.
`timescale 1ns / 1ps

package rtt_rto_pkg;

    localparam int FRAC_BITS = 8;
    localparam int TIME_BITS = 16;
    localparam int REG_W     = 16;

    // Smoothed values: integer part of TIME_BITS, fraction of FRAC_BITS.
    localparam int STATE_W   = TIME_BITS + FRAC_BITS;
    // srtt + 4 * rttvar + rounding needs three more bits.
    localparam int SUM_W     = STATE_W + 3;
    localparam int RTO_W     = SUM_W - FRAC_BITS;
    localparam int RTO_CMP_W = (RTO_W > REG_W) ? RTO_W : REG_W;
    localparam int SMP_CMP_W = (TIME_BITS > REG_W) ? TIME_BITS : REG_W;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_TIMEOUT   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TIMEOUT   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_LIMIT  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_SRTT  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_RTTVAR = CFG_IDX_W'(4);

    localparam logic [REG_W-1:0] RST_MIN_TIMEOUT    = REG_W'(50);
    localparam logic [REG_W-1:0] RST_MAX_TIMEOUT    = REG_W'(1000);
    localparam logic [REG_W-1:0] RST_SAMPLE_LIMIT   = REG_W'(5000);
    localparam logic [REG_W-1:0] RST_INITIAL_SRTT   = REG_W'(1000);
    localparam logic [REG_W-1:0] RST_INITIAL_RTTVAR = REG_W'(500);

    typedef struct packed {
        logic [15:0] now_ms;
        logic [15:0] echo_ms;
        logic        echo_valid;
    } rto_in_t;

    typedef struct packed {
        logic [15:0] timeout_ms;
        logic [15:0] srtt_ms;
        logic        sample_taken;
    } rto_out_t;

endpackage

// ===== hw/rtl/rtt_estimator_rto.sv =====
// RTT estimator with retransmit timeout, three-stage pipeline.
// Each word passes through the input register, the estimate stage and the result register.
// Throughput: one word per cycle while the output is not stalled; the only loop is the SRTT/RTTVAR update.
// Reset (aresetn, synchronous, active low) empties the pipeline, loads the
// register defaults and puts the estimate back to its initial values.
// Depends on rtt_rto_pkg and rtt_estimator_rto_assert.svh.
`timescale 1ns / 1ps

module rtt_estimator_rto (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  rtt_rto_pkg::rto_in_t                s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output rtt_rto_pkg::rto_out_t               m_data,
    input  logic                                cfg_we,
    input  logic [rtt_rto_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rtt_rto_pkg::REG_W-1:0]       cfg_wdata
);
    import rtt_rto_pkg::*;

    // The pipeline has three stages: an input register, a stage that holds
    // the updated estimate, and the result register. Each stage moves on when
    // the stage after it is empty or is moving on itself, so the block can still
    // take words while a finished result waits at the output, until the stages fill.

    // Configuration registers. The initial values are not stored: they only
    // ever load the live estimate, and a reset restores their defaults.
    logic [REG_W-1:0] min_timeout_reg;
    logic [REG_W-1:0] max_timeout_reg;
    logic [REG_W-1:0] sample_limit_reg;

    // Estimator state.
    logic [STATE_W-1:0] srtt_reg;
    logic [STATE_W-1:0] rttvar_reg;
    logic               have_sample_reg;
    logic [STATE_W-1:0] srtt_next;
    logic [STATE_W-1:0] rttvar_next;

    // Stage registers.
    logic               in_valid_reg;
    rto_in_t            in_data_reg;
    logic               mid_valid_reg;
    logic [STATE_W-1:0] mid_srtt_reg;
    logic [STATE_W-1:0] mid_rttvar_reg;
    logic               mid_taken_reg;
    logic               out_valid_reg;
    rto_out_t           out_data_reg;

    logic out_free;
    logic mid_free;
    logic in_free;
    logic in_advance;

    assign out_free   = !out_valid_reg || m_ready;
    assign mid_free   = !mid_valid_reg || out_free;
    assign in_free    = !in_valid_reg || mid_free;
    assign in_advance = in_valid_reg && mid_free;

    assign s_ready = in_free;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Configuration writes. Writes to the initial values are handled with the
    // estimate below; they load it as long as no sample has been taken yet.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_timeout_reg    <= RST_MIN_TIMEOUT;
            max_timeout_reg    <= RST_MAX_TIMEOUT;
            sample_limit_reg   <= RST_SAMPLE_LIMIT;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MIN_TIMEOUT:    min_timeout_reg    <= cfg_wdata;
                REG_MAX_TIMEOUT:    max_timeout_reg    <= cfg_wdata;
                REG_SAMPLE_LIMIT:   sample_limit_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Round-trip sample: wrapping difference of the current time and the echo.
    logic [TIME_BITS-1:0] sample;
    logic [STATE_W-1:0]   sample_fx;
    logic                 sample_ok;
    logic [STATE_W-1:0]   abs_diff;
    logic [STATE_W+1:0]   rttvar_sum;
    logic [STATE_W+2:0]   srtt_sum;

    assign sample    = TIME_BITS'(in_data_reg.now_ms) - TIME_BITS'(in_data_reg.echo_ms);
    assign sample_fx = {sample, {FRAC_BITS{1'b0}}};
    assign sample_ok = in_data_reg.echo_valid &&
                       (SMP_CMP_W'(sample) < SMP_CMP_W'(sample_limit_reg));

    // Gain 1/4 on the variance (against the old SRTT), gain 1/8 on SRTT.
    // Both are weighted means of in-range values, so the shifted sums fit.
    assign abs_diff   = (srtt_reg >= sample_fx) ? (srtt_reg - sample_fx)
                                                : (sample_fx - srtt_reg);
    assign rttvar_sum = {rttvar_reg, 1'b0} + (STATE_W+2)'(rttvar_reg)
                      + (STATE_W+2)'(abs_diff);
    assign srtt_sum   = {srtt_reg, 3'b000} - (STATE_W+3)'(srtt_reg)
                      + (STATE_W+3)'(sample_fx);

    always_comb begin
        srtt_next   = srtt_reg;
        rttvar_next = rttvar_reg;
        if (sample_ok) begin
            if (!have_sample_reg) begin
                // First sample seeds SRTT with the sample and RTTVAR with half of it.
                srtt_next   = sample_fx;
                rttvar_next = sample_fx >> 1;
            end else begin
                srtt_next   = srtt_sum[STATE_W+2:3];
                rttvar_next = rttvar_sum[STATE_W+1:2];
            end
        end
    end

    // Estimator state. Configuration writes must arrive only while the pipeline is
    // idle, so they never collide with an update; the block does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            srtt_reg        <= STATE_W'(RST_INITIAL_SRTT) << FRAC_BITS;
            rttvar_reg      <= STATE_W'(RST_INITIAL_RTTVAR) << FRAC_BITS;
            have_sample_reg <= 1'b0;
        end else if (cfg_we && !have_sample_reg && (cfg_index == REG_INITIAL_SRTT)) begin
            srtt_reg <= STATE_W'(cfg_wdata) << FRAC_BITS;
        end else if (cfg_we && !have_sample_reg && (cfg_index == REG_INITIAL_RTTVAR)) begin
            rttvar_reg <= STATE_W'(cfg_wdata) << FRAC_BITS;
        end else if (in_advance) begin
            srtt_reg   <= srtt_next;
            rttvar_reg <= rttvar_next;
            if (sample_ok) begin
                have_sample_reg <= 1'b1;
            end
        end
    end

    // Stage 1: input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_free) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_free && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // Stage 2: snapshot of the estimate as this word left it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
        end else if (mid_free) begin
            mid_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_advance) begin
            mid_srtt_reg   <= srtt_next;
            mid_rttvar_reg <= rttvar_next;
            mid_taken_reg  <= sample_ok;
        end
    end

    // Stage 3: timeout = ceil(SRTT + 4 * RTTVAR), then clamped. The minimum is
    // checked first, so with crossed limits the maximum wins unless the value is below the minimum.
    logic [SUM_W-1:0]     rto_sum;
    logic [RTO_CMP_W-1:0] rto_raw;
    logic [REG_W-1:0]     rto_clamped;

    assign rto_sum = SUM_W'(mid_srtt_reg) + (SUM_W'(mid_rttvar_reg) << 2)
                   + SUM_W'({FRAC_BITS{1'b1}});
    assign rto_raw = RTO_CMP_W'(rto_sum[SUM_W-1:FRAC_BITS]);

    always_comb begin
        if (rto_raw < RTO_CMP_W'(min_timeout_reg)) begin
            rto_clamped = min_timeout_reg;
        end else if (rto_raw > RTO_CMP_W'(max_timeout_reg)) begin
            rto_clamped = max_timeout_reg;
        end else begin
            rto_clamped = REG_W'(rto_raw);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && mid_valid_reg) begin
            out_data_reg.timeout_ms   <= rto_clamped;
            out_data_reg.srtt_ms      <= 16'(mid_srtt_reg[STATE_W-1:FRAC_BITS]);
            out_data_reg.sample_taken <= mid_taken_reg;
        end
    end

`include "rtt_estimator_rto_assert.svh"

    // A word that cannot move on stays in the input register.
    `RTO_ASSERT_NEXT(a_in_hold, in_valid_reg && !mid_free, in_valid_reg)
    // A taken sample in flight means the estimate has left its initial values.
    `RTO_ASSERT_NOW(a_mid_taken, mid_valid_reg && mid_taken_reg, have_sample_reg)
    `RTO_ASSERT_NOW(a_out_taken, out_valid_reg && out_data_reg.sample_taken, have_sample_reg)
    // Without a moving word or a write, the estimate stays put.
    `RTO_ASSERT_NEXT(a_state_idle, !in_advance && !cfg_we, $stable(srtt_reg) && $stable(rttvar_reg))

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for rtt_estimator_rto: drives input words, writes the
// registers between phases and checks each result word against its own estimator.
// Depends on rtt_rto_pkg and on the rtt_estimator_rto RTL.
`timescale 1ns / 1ps

module tb_top;

    import rtt_rto_pkg::*;

    // Generous ceiling on run length, well above the slowest legal run.
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int RANDOM_WORDS = 1250;
    localparam int HOLD_CYCLES  = 300;

    logic     aclk = 1'b0;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    rto_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    rto_out_t m_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0]     cfg_wdata;

    rtt_estimator_rto DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    // Register copies, kept in step with every write the testbench makes.
    logic [REG_W-1:0] rto_floor_ms;
    logic [REG_W-1:0] rto_ceil_ms;
    logic [REG_W-1:0] lim_ms;

    // Estimator state: fixed point with FRAC_BITS fraction bits.
    logic [STATE_W-1:0] est_srtt;
    logic [STATE_W-1:0] est_rttvar;
    logic               est_primed;

    // Result words predicted at acceptance, oldest first.
    rto_out_t pending_results[$];

    int err_count       = 0;
    int words_sent      = 0;
    int results_checked = 0;
    int samples_taken   = 0;
    int reg_writes      = 0;
    int cycle_count     = 0;

    // Traffic shaping knobs shared by the sender, the receiver and the tests.
    bit src_gapless  = 1'b0;
    bit sink_steady  = 1'b0;
    int hold_len     = 0;
    int stall_left   = 0;

    // Mostly short gaps, some medium, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Applies one register write to the local copies. Writing an initial value
    // before the first accepted sample also reloads the matching estimate.
    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [REG_W-1:0] val);
        case (idx)
            REG_MIN_TIMEOUT:  rto_floor_ms = val;
            REG_MAX_TIMEOUT:  rto_ceil_ms = val;
            REG_SAMPLE_LIMIT: lim_ms = val;
            REG_INITIAL_SRTT: begin
                if (!est_primed)
                    est_srtt = STATE_W'(val) << FRAC_BITS;
            end
            REG_INITIAL_RTTVAR: begin
                if (!est_primed)
                    est_rttvar = STATE_W'(val) << FRAC_BITS;
            end
            default: ;
        endcase
    endfunction

    // Advances the estimator by one input word and returns the result word.
    function automatic rto_out_t estimate_step(input rto_in_t w);
        logic [TIME_BITS-1:0] rtt;
        logic [STATE_W-1:0]   rtt_fx;
        logic [STATE_W-1:0]   dev;
        logic [31:0]          sum;
        logic [31:0]          rto;
        rto_out_t             res;
        rtt = w.now_ms - w.echo_ms;
        rtt_fx = STATE_W'(rtt) << FRAC_BITS;
        res.sample_taken = 1'b0;
        if (w.echo_valid && rtt < lim_ms) begin
            if (!est_primed) begin
                // The first sample seeds the variance at half the sample.
                est_srtt   = rtt_fx;
                est_rttvar = rtt_fx >> 1;
                est_primed = 1'b1;
            end else begin
                // Variance uses the old SRTT, so it is updated first.
                dev = (est_srtt >= rtt_fx) ? est_srtt - rtt_fx : rtt_fx - est_srtt;
                est_rttvar = STATE_W'((32'(est_rttvar) * 3 + 32'(dev)) >> 2);
                est_srtt   = STATE_W'((32'(est_srtt) * 7 + 32'(rtt_fx)) >> 3);
            end
            res.sample_taken = 1'b1;
        end
        // Ceiling of SRTT + 4 * RTTVAR, then clamped with the minimum checked first.
        sum = 32'(est_srtt) + 32'(est_rttvar) * 4 + (32'(1) << FRAC_BITS) - 1;
        rto = sum >> FRAC_BITS;
        if (rto < 32'(rto_floor_ms))
            rto = 32'(rto_floor_ms);
        else if (rto > 32'(rto_ceil_ms))
            rto = 32'(rto_ceil_ms);
        res.timeout_ms = rto[15:0];
        res.srtt_ms    = 16'(est_srtt >> FRAC_BITS);
        return res;
    endfunction

    function automatic rto_in_t mk_word(input logic [15:0] now, input logic [15:0] echo,
                                        input logic ev);
        rto_in_t w;
        w.now_ms     = now;
        w.echo_ms    = echo;
        w.echo_valid = ev;
        return w;
    endfunction

    // Round-trip sample biased toward the accepted range and its edges.
    function automatic logic [15:0] pick_rtt_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                if (lim_ms == 0)
                    return 16'($urandom);
                return 16'($urandom_range(0, int'(lim_ms) - 1));
            end
            6:       return 16'(int'(lim_ms) + $urandom_range(0, 2) - 1);
            7:       return 16'($urandom);
            8:       return 16'($urandom_range(0, 3));
            default: return 16'hFFFF - 16'($urandom_range(0, 3));
        endcase
    endfunction

    // Most words carry an echo; the rest are plain timer ticks.
    function automatic rto_in_t random_word();
        logic [15:0] now;
        now = 16'($urandom);
        if ($urandom_range(0, 99) < 85)
            return mk_word(now, now - pick_rtt_sample(), 1'b1);
        return mk_word(now, 16'($urandom), 1'b0);
    endfunction

    function automatic logic [15:0] pick_reg_value(input int lo, input int hi);
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    function automatic void note_error(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endfunction

    // Offers one word, holding it until the block takes it, then records the
    // expected result. A random gap may precede the word.
    task automatic send_word(input rto_in_t w);
        int gap;
        gap = src_gapless ? 0 : pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  = w;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(estimate_step(w));
        words_sent++;
    endtask

    // Drops valid and waits until every expected result word has come back.
    task automatic wait_drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        wait_drain();
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        apply_reg_write(idx, val);
        reg_writes++;
    endtask

    // Before any sample, writes to the initial values must reload the estimate.
    // A zero limit keeps every echo out, so the estimate stays unprimed.
    task automatic test_initial_values();
        send_word(mk_word(16'd100, 16'd0, 1'b0));
        write_reg(REG_MAX_TIMEOUT, 16'hFFFF);
        send_word(mk_word(16'd200, 16'd0, 1'b0));
        write_reg(REG_INITIAL_SRTT, 16'hFFFF);
        write_reg(REG_INITIAL_RTTVAR, 16'hFFFF);
        send_word(mk_word(16'hFFFF, 16'hFFFF, 1'b0));
        write_reg(REG_SAMPLE_LIMIT, 16'h0000);
        send_word(mk_word(16'd10, 16'd0, 1'b1));
        write_reg(REG_INITIAL_SRTT, 16'h0000);
        write_reg(REG_INITIAL_RTTVAR, 16'h0000);
        write_reg(REG_MIN_TIMEOUT, 16'h0000);
        send_word(mk_word(16'd0, 16'hFFFF, 1'b1));
        write_reg(REG_MIN_TIMEOUT, 16'd7);
        send_word(mk_word(16'd0, 16'd0, 1'b0));
    endtask

    // First sample, wrap-around of the time difference and both sides of the limit.
    task automatic test_field_extremes();
        write_reg(REG_MIN_TIMEOUT, 16'h0000);
        write_reg(REG_SAMPLE_LIMIT, RST_SAMPLE_LIMIT);
        write_reg(REG_INITIAL_SRTT, RST_INITIAL_SRTT);
        write_reg(REG_INITIAL_RTTVAR, RST_INITIAL_RTTVAR);
        send_word(mk_word(16'h0000, 16'h0000, 1'b1));
        send_word(mk_word(16'hFFFF, 16'h0000, 1'b1));
        send_word(mk_word(16'h0000, 16'hFFFF, 1'b1));
        send_word(mk_word(16'd5000, 16'd0, 1'b1));
        send_word(mk_word(16'd5099, 16'd100, 1'b1));
        send_word(mk_word(16'hFFFF, 16'hFFFF, 1'b1));
        send_word(mk_word(16'hFFFF, 16'hFFFF, 1'b0));
        // With the widest limit the largest samples push the sum to its top bits.
        write_reg(REG_SAMPLE_LIMIT, 16'hFFFF);
        send_word(mk_word(16'hFFFE, 16'hFFFF, 1'b1));
        send_word(mk_word(16'hFFFD, 16'hFFFF, 1'b1));
        // After the first sample the initial values must not touch the estimate.
        write_reg(REG_INITIAL_SRTT, 16'd3);
        write_reg(REG_INITIAL_RTTVAR, 16'd3);
        send_word(mk_word(16'd40, 16'd0, 1'b1));
    endtask

    // Clamp order, including a minimum above the maximum.
    task automatic test_clamp_orders();
        write_reg(REG_MIN_TIMEOUT, 16'd100);
        write_reg(REG_MAX_TIMEOUT, 16'd200);
        send_word(mk_word(16'd0, 16'd0, 1'b1));
        write_reg(REG_MIN_TIMEOUT, 16'hFFFF);
        write_reg(REG_MAX_TIMEOUT, 16'h0000);
        send_word(mk_word(16'd5, 16'd0, 1'b1));
        write_reg(REG_MIN_TIMEOUT, 16'h0000);
        send_word(mk_word(16'd5, 16'd0, 1'b0));
        write_reg(REG_MAX_TIMEOUT, 16'hFFFF);
        send_word(mk_word(16'd900, 16'd0, 1'b1));
    endtask

    // Writes to indexes past the last register must change nothing.
    task automatic test_unknown_index();
        for (int i = int'(REG_INITIAL_RTTVAR) + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), 16'($urandom));
        send_word(mk_word(16'd77, 16'd7, 1'b1));
        send_word(mk_word(16'd78, 16'd0, 1'b0));
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // words back to back, so the pipeline fills and stalls its input. Then the
    // sender pauses until every result has come back, then sends ten more words.
    task automatic test_backpressure();
        wait_drain();
        src_gapless = 1'b1;
        hold_len    = HOLD_CYCLES;
        repeat (40) send_word(random_word());
        src_gapless = 1'b0;
        wait_drain();
        repeat (10) send_word(random_word());
    endtask

    // Random traffic in phases, each with its own register settings and idling.
    task automatic test_random_traffic(input int n_words);
        int per_phase;
        per_phase = n_words / 6;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_MIN_TIMEOUT, 16'h0000);
                    write_reg(REG_MAX_TIMEOUT, 16'hFFFF);
                    write_reg(REG_SAMPLE_LIMIT, 16'hFFFF);
                end
                1, 2: begin
                    write_reg(REG_MIN_TIMEOUT, 16'($urandom_range(0, 300)));
                    write_reg(REG_MAX_TIMEOUT, 16'($urandom_range(300, 8000)));
                    write_reg(REG_SAMPLE_LIMIT, 16'($urandom_range(100, 20000)));
                end
                3: begin
                    write_reg(REG_MIN_TIMEOUT, 16'($urandom_range(2000, 6000)));
                    write_reg(REG_MAX_TIMEOUT, 16'($urandom_range(0, 1500)));
                    write_reg(REG_SAMPLE_LIMIT, 16'($urandom_range(100, 20000)));
                end
                4: begin
                    write_reg(REG_MIN_TIMEOUT, pick_reg_value(0, 2000));
                    write_reg(REG_MAX_TIMEOUT, pick_reg_value(0, 65535));
                    write_reg(REG_SAMPLE_LIMIT, pick_reg_value(1, 65535));
                end
                default: begin
                    write_reg(REG_MIN_TIMEOUT, RST_MIN_TIMEOUT);
                    write_reg(REG_MAX_TIMEOUT, RST_MAX_TIMEOUT);
                    write_reg(REG_SAMPLE_LIMIT, RST_SAMPLE_LIMIT);
                end
            endcase
            write_reg(REG_INITIAL_SRTT, 16'($urandom));
            write_reg(REG_INITIAL_RTTVAR, 16'($urandom));
            // One phase runs with no idling on either side.
            src_gapless = (phase == 2);
            sink_steady = (phase == 2);
            repeat (per_phase) send_word(random_word());
        end
        src_gapless = 1'b0;
        sink_steady = 1'b0;
    endtask

    // Receiver: random stalls, plus a long hold-off counted here on request.
    initial begin : sink_ctl
        int n;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_len > 0) begin
                n = hold_len;
                hold_len = 0;
                m_ready = 1'b0;
                repeat (n - 1) @(negedge aclk);
            end else if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else if (sink_steady || $urandom_range(0, 99) < 75) begin
                m_ready = 1'b1;
            end else begin
                m_ready = 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    // Checks each accepted result word against the oldest prediction.
    always @(posedge aclk) begin : result_check
        rto_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                note_error($sformatf("unexpected result timeout=%0d srtt=%0d taken=%0b",
                                     m_data.timeout_ms, m_data.srtt_ms, m_data.sample_taken));
            end else begin
                want = pending_results.pop_front();
                if (m_data.timeout_ms !== want.timeout_ms || m_data.srtt_ms !== want.srtt_ms ||
                    m_data.sample_taken !== want.sample_taken)
                    note_error($sformatf(
                        "word %0d: expected timeout=%0d srtt=%0d taken=%0b, got %0d %0d %0b",
                        results_checked, want.timeout_ms, want.srtt_ms, want.sample_taken,
                        m_data.timeout_ms, m_data.srtt_ms, m_data.sample_taken));
                if (want.sample_taken)
                    samples_taken++;
                results_checked++;
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        rto_floor_ms   = RST_MIN_TIMEOUT;
        rto_ceil_ms    = RST_MAX_TIMEOUT;
        lim_ms         = RST_SAMPLE_LIMIT;
        est_srtt   = STATE_W'(RST_INITIAL_SRTT) << FRAC_BITS;
        est_rttvar = STATE_W'(RST_INITIAL_RTTVAR) << FRAC_BITS;
        est_primed = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        // The initial-value test must run first, while no sample has been taken.
        test_initial_values();
        test_field_extremes();
        test_clamp_orders();
        test_unknown_index();
        test_backpressure();
        test_random_traffic(RANDOM_WORDS);

        wait_drain();
        repeat (10) @(posedge aclk);
        $display("Run covered %0d words, %0d results checked, %0d samples taken,",
                 words_sent, results_checked, samples_taken);
        $display("%0d register writes across directed, back-pressure and random phases.",
                 reg_writes);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
